// ===== hdl/hbe_pkg.sv =====
package hbe_pkg;

  localparam int COORD_BITS      = 20;
  localparam int XYZ_BITS        = 3 * COORD_BITS;
  localparam int COORD_FRAC_BITS = 8;
  localparam int RECIP_BITS      = 18;
  localparam int RES_BITS        = 12;
  localparam int RES_DEPTH       = 1 << RES_BITS;
  localparam int ENERGY_BITS     = 18;

  // Squared distance: three squares of 21-bit differences.
  localparam int SQ_BITS     = 42;
  // Numerator 2^NUM_SHIFT of the reciprocal division.
  localparam int NUM_SHIFT   = 2 * COORD_FRAC_BITS + 2 * RECIP_BITS;
  localparam int LIMIT_SHIFT = 2 * COORD_FRAC_BITS - 2;
  localparam int QUO_BITS    = 40;
  localparam int ROOT_STEPS  = QUO_BITS / 2;
  localparam int SUM_BITS    = 22;
  localparam int PROD_BITS   = 38;

  localparam logic signed [15:0] NEG_COUPLING = -16'sd27888;
  localparam logic signed [ENERGY_BITS-1:0] MIN_ENERGY = -18'sd9900;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_FIRST  = 2'd1,
    HIT_SECOND = 2'd2
  } slot_hit_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_SUM, F_DIV, F_SQRT, F_ACC, F_MUL, F_RND
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR, B_IDLE, B_READ, B_UPD
  } back_state_t;

  typedef struct packed {
    logic signed [ENERGY_BITS-1:0] energy;
    logic [RES_BITS-1:0]           donor;
    logic [RES_BITS-1:0]           acceptor;
  } bond_t;

endpackage

// ===== hdl/hbe_queue.sv =====
module hbe_queue
  import hbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  bond_t din,
  input  logic  pop,
  output bond_t dout,
  output logic  full,
  output logic  empty
);

  bond_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

endmodule

// ===== hdl/hbe_front.sv =====
module hbe_front
  import hbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start_ok,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [XYZ_BITS-1:0] donor_n_xyz,
  input  logic [XYZ_BITS-1:0] donor_h_xyz,
  input  logic [XYZ_BITS-1:0] acceptor_c_xyz,
  input  logic [XYZ_BITS-1:0] acceptor_o_xyz,
  input  logic                donor_is_proline,
  input  logic [RES_BITS-1:0] donor_index,
  input  logic [RES_BITS-1:0] acceptor_index,
  output logic                q_push,
  output bond_t               q_data,
  input  logic                q_full
);

  front_state_t state, state_next;

  logic [XYZ_BITS-1:0] n_xyz, h_xyz, c_xyz, o_xyz;
  logic                prol;
  logic [RES_BITS-1:0] di, ai;
  logic [1:0]          pair;
  logic [SQ_BITS-2:0]  sqx, sqy, sqz;
  logic [SQ_BITS-1:0]  sq;
  logic                close;
  logic [SQ_BITS-1:0]  rem;
  logic [QUO_BITS-1:0] quo;
  logic [5:0]          cnt;
  logic [QUO_BITS-1:0] xr, res, bitv;
  logic signed [SUM_BITS-1:0]  s;
  logic signed [PROD_BITS-1:0] p;

  logic                accept;
  logic [XYZ_BITS-1:0] a_xyz, b_xyz;
  logic signed [COORD_BITS:0]  d [3];
  logic signed [SQ_BITS-1:0]   dsq [3];
  logic [SQ_BITS-1:0]  sq_sum;
  logic                too_close;
  logic [SQ_BITS:0]    rem_sh, rem_sub;
  logic                div_ge;
  logic [QUO_BITS-1:0] root_try;
  logic                root_ge;
  logic [PROD_BITS-1:0] p_abs, p_rnd;
  logic [19:0]          mag;
  logic signed [20:0]   e_raw;
  logic signed [ENERGY_BITS-1:0] e_out;

  // Pair order: H-O, H-C, N-C, N-O; odd pairs enter the sum negated.
  assign a_xyz = pair[1] ? n_xyz : h_xyz;
  assign b_xyz = (pair == 2'd1 || pair == 2'd2) ? c_xyz : o_xyz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = $signed({a_xyz[COORD_BITS*k + COORD_BITS - 1], a_xyz[COORD_BITS*k +: COORD_BITS]})
           - $signed({b_xyz[COORD_BITS*k + COORD_BITS - 1], b_xyz[COORD_BITS*k +: COORD_BITS]});
      dsq[k] = SQ_BITS'(d[k]) * SQ_BITS'(d[k]);
    end
  end

  assign sq_sum    = {1'b0, sqx} + {1'b0, sqy} + {1'b0, sqz};
  assign too_close = sq_sum < (SQ_BITS'(1) << LIMIT_SHIFT);

  assign rem_sh  = {rem, (cnt == 6'(NUM_SHIFT))};
  assign div_ge  = rem_sh >= {1'b0, sq};
  assign rem_sub = rem_sh - {1'b0, sq};

  assign root_try = res + bitv;
  assign root_ge  = xr >= root_try;

  assign p_abs = p[PROD_BITS-1] ? PROD_BITS'(-p) : PROD_BITS'(p);
  assign p_rnd = p_abs + (PROD_BITS'(1) << (RECIP_BITS - 1));
  assign mag   = p_rnd[RECIP_BITS +: 20];
  assign e_raw = p[PROD_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_comb begin
    if (prol) e_out = '0;
    else if (close) e_out = MIN_ENERGY;
    else if (e_raw < 21'(MIN_ENERGY)) e_out = MIN_ENERGY;
    else e_out = e_raw[ENERGY_BITS-1:0];
  end

  assign accept = in_valid && !in_stall;
  assign q_data = '{energy: e_out, donor: di, acceptor: ai};

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    q_push     = 1'b0;
    case (state)
      F_IDLE: begin
        in_stall = !start_ok;
        if (accept) state_next = F_SQ;
      end
      F_SQ:   state_next = F_SUM;
      F_SUM:  state_next = too_close ? F_ACC : F_DIV;
      F_DIV:  if (cnt == 6'd0) state_next = F_SQRT;
      F_SQRT: if (cnt == 6'd0) state_next = F_ACC;
      F_ACC:  state_next = (pair == 2'd3) ? F_MUL : F_SQ;
      F_MUL:  state_next = F_RND;
      F_RND: begin
        q_push = !q_full;
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          n_xyz <= donor_n_xyz;
          h_xyz <= donor_h_xyz;
          c_xyz <= acceptor_c_xyz;
          o_xyz <= acceptor_o_xyz;
          prol  <= donor_is_proline;
          di    <= donor_index;
          ai    <= acceptor_index;
          pair  <= 2'd0;
          close <= 1'b0;
          s     <= '0;
        end
      end
      F_SQ: begin
        sqx <= dsq[0][SQ_BITS-2:0];
        sqy <= dsq[1][SQ_BITS-2:0];
        sqz <= dsq[2][SQ_BITS-2:0];
      end
      F_SUM: begin
        sq  <= sq_sum;
        rem <= '0;
        quo <= '0;
        cnt <= 6'(NUM_SHIFT);
        res <= '0;
        if (too_close) close <= 1'b1;
      end
      F_DIV: begin
        rem <= div_ge ? rem_sub[SQ_BITS-1:0] : rem_sh[SQ_BITS-1:0];
        quo <= {quo[QUO_BITS-2:0], div_ge};
        if (cnt == 6'd0) begin
          xr   <= {quo[QUO_BITS-2:0], div_ge};
          res  <= '0;
          bitv <= QUO_BITS'(1) << (QUO_BITS - 2);
          cnt  <= 6'(ROOT_STEPS - 1);
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
      F_SQRT: begin
        if (root_ge) begin
          xr  <= xr - root_try;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 6'd1;
      end
      F_ACC: begin
        if (pair[0]) s <= s - $signed({1'b0, res[SUM_BITS-2:0]});
        else s <= s + $signed({1'b0, res[SUM_BITS-2:0]});
        pair <= pair + 2'd1;
      end
      F_MUL: p <= PROD_BITS'(s) * PROD_BITS'(NEG_COUPLING);
      default: ;
    endcase
  end

endmodule

// ===== hdl/hbe_back.sv =====
module hbe_back
  import hbe_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  output logic                          ready,
  input  logic                          q_empty,
  input  bond_t                         q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ENERGY_BITS-1:0] energy_milli,
  output logic [1:0]                    donor_slot_hit,
  output logic [1:0]                    acceptor_slot_hit
);

  typedef struct packed {
    logic signed [ENERGY_BITS-1:0] e1;
    logic [RES_BITS-1:0]           p1;
    logic signed [ENERGY_BITS-1:0] e2;
    logic [RES_BITS-1:0]           p2;
  } row_t;

  typedef struct packed {
    row_t      row;
    slot_hit_t hit;
  } offer_t;

  function automatic offer_t offer(row_t r, logic signed [ENERGY_BITS-1:0] e,
                                   logic [RES_BITS-1:0] partner);
    offer_t o;
    o.row = r;
    o.hit = HIT_NONE;
    if (e < r.e1) begin
      o.row = '{e1: e, p1: partner, e2: r.e1, p2: r.p1};
      o.hit = HIT_FIRST;
    end else if (e < r.e2) begin
      o.row.e2 = e;
      o.row.p2 = partner;
      o.hit    = HIT_SECOND;
    end
    return o;
  endfunction

  back_state_t state, state_next;

  row_t acc_mem [RES_DEPTH];
  row_t don_mem [RES_DEPTH];
  row_t acc_rd, don_rd;

  logic [RES_BITS-1:0] clr_cnt;
  bond_t               cur;
  offer_t              acc_off, don_off;
  logic                take;
  logic                clearing;

  assign clearing = (state == B_CLEAR);
  assign ready    = !clearing;
  assign acc_off  = offer(acc_rd, cur.energy, cur.acceptor);
  assign don_off  = offer(don_rd, cur.energy, cur.donor);

  always_ff @(posedge clk) begin
    if (rst) state <= B_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    take       = 1'b0;
    case (state)
      B_CLEAR: if (clr_cnt == RES_BITS'(RES_DEPTH - 1)) state_next = B_IDLE;
      B_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty) state_next = B_READ;
      end
      B_READ: state_next = B_UPD;
      B_UPD: begin
        take = !out_valid || !out_stall;
        if (take) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + RES_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    acc_rd <= acc_mem[cur.donor];
    don_rd <= don_mem[cur.acceptor];
    if (clearing) begin
      acc_mem[clr_cnt] <= '0;
      don_mem[clr_cnt] <= '0;
    end else if (take) begin
      acc_mem[cur.donor]    <= acc_off.row;
      don_mem[cur.acceptor] <= don_off.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (take) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      energy_milli      <= cur.energy;
      donor_slot_hit    <= acc_off.hit;
      acceptor_slot_hit <= don_off.hit;
    end
  end

endmodule

// ===== hdl/hbond_energy_top2_tracker.sv =====
// Backbone hydrogen-bond energy with a per-residue record of the two strongest
// bonds. Each input transaction carries one donor/acceptor residue pair; each
// output transaction returns its energy in 0.001 kcal/mol and which slot of the
// donor's best-acceptor record and of the acceptor's best-donor record changed.
// After reset the block clears all 4096 rows of both record tables and
// holds in_stall high meanwhile. In the front end, each of the four distances
// of an item then goes through one bit-serial divider and one bit-serial
// square root unit, after squaring and summing and before accumulation;
// a close contact skips the divide and root for that distance. The back end
// reads and then rewrites the tables behind a two-entry queue, so it
// overlaps the next item's arithmetic, and a registered output lets a
// finished result wait without blocking the front end.
module hbond_energy_top2_tracker
  import hbe_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [XYZ_BITS-1:0]           donor_n_xyz,
  input  logic [XYZ_BITS-1:0]           donor_h_xyz,
  input  logic [XYZ_BITS-1:0]           acceptor_c_xyz,
  input  logic [XYZ_BITS-1:0]           acceptor_o_xyz,
  input  logic                          donor_is_proline,
  input  logic [RES_BITS-1:0]           donor_index,
  input  logic [RES_BITS-1:0]           acceptor_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ENERGY_BITS-1:0] energy_milli,
  output logic [1:0]                    donor_slot_hit,
  output logic [1:0]                    acceptor_slot_hit
);

  logic  q_push, q_pop, q_full, q_empty;
  bond_t q_in, q_out;
  logic  back_ready;

  // Front end: latches a transaction and computes its energy.
  hbe_front u_front (
    .clk              (clk),
    .rst              (rst),
    .start_ok         (back_ready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .donor_n_xyz      (donor_n_xyz),
    .donor_h_xyz      (donor_h_xyz),
    .acceptor_c_xyz   (acceptor_c_xyz),
    .acceptor_o_xyz   (acceptor_o_xyz),
    .donor_is_proline (donor_is_proline),
    .donor_index      (donor_index),
    .acceptor_index   (acceptor_index),
    .q_push           (q_push),
    .q_data           (q_in),
    .q_full           (q_full)
  );

  // Energies and indices wait here for the table update.
  hbe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back end: clears the tables after reset, then updates the two best slots.
  hbe_back u_back (
    .clk               (clk),
    .rst               (rst),
    .ready             (back_ready),
    .q_empty           (q_empty),
    .q_data            (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .energy_milli      (energy_milli),
    .donor_slot_hit    (donor_slot_hit),
    .acceptor_slot_hit (acceptor_slot_hit)
  );

endmodule

// ===== test/hbond_checker.sv =====
`timescale 1ns / 1ps

module hbond_checker
  import hbe_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [XYZ_BITS-1:0]           donor_n_xyz,
  input  logic [XYZ_BITS-1:0]           donor_h_xyz,
  input  logic [XYZ_BITS-1:0]           acceptor_c_xyz,
  input  logic [XYZ_BITS-1:0]           acceptor_o_xyz,
  input  logic                          donor_is_proline,
  input  logic [RES_BITS-1:0]           donor_index,
  input  logic [RES_BITS-1:0]           acceptor_index,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [ENERGY_BITS-1:0] energy_milli,
  input  logic [1:0]                    donor_slot_hit,
  input  logic [1:0]                    acceptor_slot_hit,
  output int                            errors,
  output int                            pending
);

  typedef struct {
    logic signed [ENERGY_BITS-1:0] energy;
    slot_hit_t                     donor_hit;
    slot_hit_t                     acceptor_hit;
  } bond_result_t;

  typedef struct {
    int          energy;
    logic [11:0] partner;
  } best_slot_t;

  best_slot_t   acc_first [RES_DEPTH];
  best_slot_t   acc_second[RES_DEPTH];
  best_slot_t   don_first [RES_DEPTH];
  best_slot_t   don_second[RES_DEPTH];
  bond_result_t bond_q[$];
  int           err_count = 0;

  assign errors = err_count;

  function automatic longint axis(logic [XYZ_BITS-1:0] p, int k);
    logic signed [COORD_BITS-1:0] c;
    c = p[COORD_BITS*k +: COORD_BITS];
    return longint'(c);
  endfunction

  function automatic longint dist_sq(logic [XYZ_BITS-1:0] a, logic [XYZ_BITS-1:0] b);
    longint sum;
    longint d;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d = axis(a, k) - axis(b, k);
      sum += d * d;
    end
    return sum;
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint inv_dist(longint sq);
    longint unsigned num;
    num = 64'd1 << NUM_SHIFT;
    return root_floor(num / longint'(sq));
  endfunction

  function automatic int bond_energy(logic [XYZ_BITS-1:0] n, logic [XYZ_BITS-1:0] h,
                                     logic [XYZ_BITS-1:0] c, logic [XYZ_BITS-1:0] o,
                                     logic pro);
    longint sho, shc, snc, sno, lim, s, p, mag, e;
    if (pro) return 0;
    lim = longint'(1) << LIMIT_SHIFT;
    sho = dist_sq(h, o);
    shc = dist_sq(h, c);
    snc = dist_sq(n, c);
    sno = dist_sq(n, o);
    if (sho < lim || shc < lim || snc < lim || sno < lim) return int'(MIN_ENERGY);
    s = inv_dist(sho) - inv_dist(shc) + inv_dist(snc) - inv_dist(sno);
    p = -27888 * s;
    mag = ((p < 0 ? -p : p) + (longint'(1) << (RECIP_BITS - 1))) >>> RECIP_BITS;
    e = p < 0 ? -mag : mag;
    if (e < longint'(MIN_ENERGY)) e = longint'(MIN_ENERGY);
    return int'(e);
  endfunction

  // A strictly lower energy takes the first slot and pushes the old one down;
  // otherwise it may still replace the second slot.
  function automatic slot_hit_t offer(ref best_slot_t first, ref best_slot_t second,
                                      input int e, input logic [11:0] partner);
    if (e < first.energy) begin
      second = first;
      first.energy = e;
      first.partner = partner;
      return HIT_FIRST;
    end
    if (e < second.energy) begin
      second.energy = e;
      second.partner = partner;
      return HIT_SECOND;
    end
    return HIT_NONE;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    bond_result_t r;
    bond_result_t w;
    int e;
    if (rst) begin
      foreach (acc_first[i]) begin
        acc_first[i]  = '{0, '0};
        acc_second[i] = '{0, '0};
        don_first[i]  = '{0, '0};
        don_second[i] = '{0, '0};
      end
      bond_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        e = bond_energy(donor_n_xyz, donor_h_xyz, acceptor_c_xyz, acceptor_o_xyz,
                        donor_is_proline);
        r.energy       = e[ENERGY_BITS-1:0];
        r.donor_hit    = offer(acc_first[donor_index], acc_second[donor_index], e,
                               acceptor_index);
        r.acceptor_hit = offer(don_first[acceptor_index], don_second[acceptor_index], e,
                               donor_index);
        bond_q = {bond_q, r};
      end
      if (out_valid && !out_stall) begin
        if (bond_q.size() == 0) begin
          report("unexpected transaction", int'(energy_milli), 0);
        end else begin
          w = bond_q.pop_front();
          if (energy_milli !== w.energy)
            report("energy_milli", int'(energy_milli), int'(w.energy));
          if (donor_slot_hit !== w.donor_hit)
            report("donor_slot_hit", int'(donor_slot_hit), int'(w.donor_hit));
          if (acceptor_slot_hit !== w.acceptor_hit)
            report("acceptor_slot_hit", int'(acceptor_slot_hit), int'(w.acceptor_hit));
        end
      end
    end
    pending <= bond_q.size();
  end

endmodule

// ===== test/tb_hbond_energy_top2_tracker.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the hydrogen-bond energy tracker. The checker module
// beside the block does all prediction and comparison; this module only makes
// transactions, applies back pressure and decides pass or fail.
module tb_hbond_energy_top2_tracker;
  import hbe_pkg::*;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [XYZ_BITS-1:0]           donor_n_xyz = '0;
  logic [XYZ_BITS-1:0]           donor_h_xyz = '0;
  logic [XYZ_BITS-1:0]           acceptor_c_xyz = '0;
  logic [XYZ_BITS-1:0]           acceptor_o_xyz = '0;
  logic                          donor_is_proline = 1'b0;
  logic [RES_BITS-1:0]           donor_index = '0;
  logic [RES_BITS-1:0]           acceptor_index = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [ENERGY_BITS-1:0] energy_milli;
  logic [1:0]                    donor_slot_hit;
  logic [1:0]                    acceptor_slot_hit;
  int                            errors;
  int                            pending;

  // Control shared between the sender and the receiver process.
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hbond_energy_top2_tracker dut (.*);

  hbond_checker chk (.*);

  // Receiver side. It normally throws in short random stalls, serves one long
  // hold-off when asked so the block backs up into its input, and stops
  // stalling altogether once the run enters its quiet tail.
  initial begin
    bit served;
    served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !served) begin
        served = 1'b1;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // The slowest legal run is far below this: roughly 750 transactions, plus
  // the table clear and the long hold-off.
  initial begin
    #20_000_000;
    $display("** hbond_energy_top2_tracker: FAILED **");
    $finish;
  end

  function automatic logic [XYZ_BITS-1:0] pack3(int x, int y, int z);
    logic [COORD_BITS-1:0] a, b, c;
    a = x[COORD_BITS-1:0];
    b = y[COORD_BITS-1:0];
    c = z[COORD_BITS-1:0];
    return {c, b, a};
  endfunction

  function automatic logic [XYZ_BITS-1:0] full_random();
    return XYZ_BITS'({$urandom, $urandom});
  endfunction

  function automatic int jitter(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Drives one transaction and returns once it has been accepted. The stall
  // is looked at on the falling edge, where it is settled for the next rising
  // edge. Valid stays high when the next transaction follows directly.
  task automatic send(logic [XYZ_BITS-1:0] n, logic [XYZ_BITS-1:0] h,
                      logic [XYZ_BITS-1:0] c, logic [XYZ_BITS-1:0] o,
                      logic pro, logic [RES_BITS-1:0] di, logic [RES_BITS-1:0] ai);
    donor_n_xyz      <= n;
    donor_h_xyz      <= h;
    acceptor_c_xyz   <= c;
    acceptor_o_xyz   <= o;
    donor_is_proline <= pro;
    donor_index      <= di;
    acceptor_index   <= ai;
    in_valid         <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // A backbone-like pair: N-H about one angstrom, H..O a couple of angstroms,
  // C=O about 1.2 angstroms, all in 1/256 units around a random origin.
  task automatic send_bond(logic pro, logic [RES_BITS-1:0] di, logic [RES_BITS-1:0] ai);
    int nx, ny, nz, hx, hy, hz, ox, oy, oz;
    nx = jitter(1 << 18);
    ny = jitter(1 << 18);
    nz = jitter(1 << 18);
    hx = nx + jitter(200);
    hy = ny + jitter(200);
    hz = nz + jitter(200);
    ox = hx + jitter(700);
    oy = hy + jitter(700);
    oz = hz + jitter(700);
    send(pack3(nx, ny, nz), pack3(hx, hy, hz),
         pack3(ox + jitter(250), oy + jitter(250), oz + jitter(250)),
         pack3(ox, oy, oz), pro, di, ai);
  endtask

  function automatic logic [RES_BITS-1:0] pick_index();
    if ($urandom_range(0, 4) != 0) return RES_BITS'($urandom_range(0, 15));
    return RES_BITS'($urandom);
  endfunction

  initial begin
    logic [XYZ_BITS-1:0] top_corner, low_corner;
    top_corner = pack3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    low_corner = pack3(20'h80000, 20'h80000, 20'h80000);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Every coordinate zero means every distance is zero, the
    // close contact case. A proline donor must give zero energy even when the
    // geometry would be a clash.
    send('0, '0, '0, '0, 1'b0, 12'd0, 12'd0);
    send('0, '0, '0, '0, 1'b1, 12'd4095, 12'd4095);
    // Opposite corners of the coordinate range give the longest distances.
    send(top_corner, low_corner, top_corner, low_corner, 1'b0, 12'd4095, 12'd0);
    send(low_corner, top_corner, low_corner, top_corner, 1'b0, 12'd0, 12'd4095);
    send(top_corner, top_corner, low_corner, low_corner, 1'b0, 12'd1, 12'd2);
    send(low_corner, low_corner, top_corner, top_corner, 1'b1, 12'd2, 12'd1);
    // Hydrogen sitting on the oxygen: one distance only is a clash.
    send(pack3(0, 0, 0), pack3(256, 0, 0), pack3(256, 300, 0), pack3(256, 0, 0),
         1'b0, 12'd7, 12'd8);
    // Just inside and just outside the half-angstrom contact limit.
    send(pack3(0, 0, 0), pack3(256, 0, 0), pack3(1000, 0, 0), pack3(383, 0, 0),
         1'b0, 12'd9, 12'd10);
    send(pack3(0, 0, 0), pack3(256, 0, 0), pack3(1000, 0, 0), pack3(384, 0, 0),
         1'b0, 12'd9, 12'd10);
    // A near-ideal bond repeated against one residue, then a donor row shared
    // with itself as acceptor, so the first and second slots both move.
    for (int i = 0; i < 6; i++) send_bond(1'b0, 12'd20, 12'd21 + i[11:0]);
    for (int i = 0; i < 4; i++) send_bond(1'b0, 12'd30, 12'd30);
    for (int i = 0; i < 3; i++) send_bond(1'b1, 12'd20, 12'd21);

    // Random part. Most transactions are bond-like with indices bunched on a
    // few rows so the ranking logic is exercised; the rest are raw noise.
    for (int i = 0; i < 750; i++) begin
      if (i == 150) hold_req = 1'b1;
      if (i == 400) begin
        // Drop valid and let the checker count the last accepted transaction
        // before waiting for the block to drain.
        in_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      if (i == 650) quiet = 1'b1;
      if ($urandom_range(0, 9) < 7)
        send_bond($urandom_range(0, 15) == 0, pick_index(), pick_index());
      else
        send(full_random(), full_random(), full_random(), full_random(),
             1'($urandom), RES_BITS'($urandom), RES_BITS'($urandom));
    end
    in_valid <= 1'b0;

    @(negedge clk);
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("** hbond_energy_top2_tracker: PASSED **");
    else
      $display("** hbond_energy_top2_tracker: FAILED **");
    $finish;
  end

endmodule
